@@ rtl/core/fasm_pkg.sv @@
// shared types and constants for the float32 add/sub/mul unit
`default_nettype none
package fasm_pkg;
   localparam logic [31:0] SIGN_BIT   = 32'h8000_0000;
   localparam logic [31:0] EXP_MASK   = 32'h7f80_0000;
   localparam logic [31:0] FRAC_MASK  = 32'h3fff_ffff;
   localparam logic [31:0] HIDDEN_ONE = 32'h4000_0000;
   localparam logic [31:0] MANT_MASK  = 32'h007f_ffff;
   localparam int EXP_BIAS  = 127;
   localparam int MANT_BITS = 23;

   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_SUB = 2'd1,
      OP_MUL = 2'd2,
      OP_MUL_ALT = 2'd3
   } op_type;

   // classified item handed from front to back
   typedef struct packed {
      logic        is_mul;
      logic        bypass;
      logic [31:0] bypass_word;
      logic        s1;
      logic        s2;
      logic signed [9:0] e1;
      logic signed [9:0] e2;
      logic [31:0] f1;
      logic [31:0] f2;
   } item_type;

   function automatic logic [31:0] q30_frac(input logic [31:0] w);
      q30_frac = (((w << 9) >> 2) & FRAC_MASK) + HIDDEN_ONE;
   endfunction
endpackage
`default_nettype wire

@@ rtl/core/fasm_if.sv @@
// valid/ready channel interfaces
`default_nettype none
interface fasm_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  req_type;
   logic [31:0] operand_a;
   logic [31:0] operand_b;
   modport source (output valid, req_type, operand_a, operand_b, input ready);
   modport sink (input valid, req_type, operand_a, operand_b, output ready);
endinterface

interface fasm_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] result_word;
   modport source (output valid, result_word, input ready);
   modport sink (input valid, result_word, output ready);
endinterface
`default_nettype wire

@@ rtl/core/float32_add_sub_mul_top.sv @@
// top level of the float32 add/sub/mul unit
// a request passes through the front register, a queue entry and back stages 1 and 2 before its result is valid
// throughput: one request per cycle while no stage is stalled by the ready of the stage after it
// front, queue and back each stall on the ready of the stage downstream
// reset: synchronous, active high, clears all valid flags and pointers
`default_nettype none
module float32_add_sub_mul_top import fasm_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   fasm_req_if.sink  req,
   fasm_rsp_if.source rsp
);
   item_type fi, qi;
   logic fv, fr, qv, qr;

   fasm_front u_front (.clock, .reset, .req, .item_out(fi), .item_valid(fv),
      .item_ready(fr));
   fasm_queue u_queue (.clock, .reset, .wr_item(fi), .wr_valid(fv), .wr_ready(fr),
      .rd_item(qi), .rd_valid(qv), .rd_ready(qr));
   fasm_back u_back (.clock, .reset, .item(qi), .item_valid(qv), .item_ready(qr),
      .rsp);
endmodule
`default_nettype wire

@@ rtl/core/fasm_front.sv @@
// front end: accepts requests, unpacks and classifies operands
`default_nettype none
module fasm_front import fasm_pkg::*; (
   input  wire logic  clock,
   input  wire logic  reset,
   fasm_req_if.sink   req,
   output item_type   item_out,
   output logic       item_valid,
   input  wire logic  item_ready
);
   item_type item_ff, item_in;
   logic     valid_ff;
   logic [31:0] b_eff;
   logic za, zb;

   assign req.ready  = !valid_ff || item_ready;
   assign item_out   = item_ff;
   assign item_valid = valid_ff;

   always_comb begin
      b_eff = (req.req_type == OP_SUB) ? (req.operand_b ^ SIGN_BIT) : req.operand_b;
      za = (req.operand_a[30:0] == 31'd0);
      zb = (b_eff[30:0] == 31'd0);
      item_in.is_mul = req.req_type[1];
      item_in.s1 = req.operand_a[31];
      item_in.s2 = b_eff[31];
      item_in.e1 = $signed({2'b00, req.operand_a[30:23]}) - 10'sd127;
      item_in.e2 = $signed({2'b00, b_eff[30:23]}) - 10'sd127;
      item_in.f1 = q30_frac(req.operand_a);
      item_in.f2 = q30_frac(b_eff);
      if (req.req_type[1]) begin
         item_in.bypass = za || zb;
         item_in.bypass_word = 32'd0;
      end else begin
         item_in.bypass = za || zb;
         item_in.bypass_word = za ? b_eff : req.operand_a;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (req.ready) begin
         valid_ff <= req.valid;
      end
      if (req.ready && req.valid) begin
         item_ff <= item_in;
      end
   end
endmodule
`default_nettype wire

@@ rtl/core/fasm_queue.sv @@
// two-entry queue between front and back
`default_nettype none
module fasm_queue import fasm_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   input  item_type  wr_item,
   input  wire logic wr_valid,
   output logic      wr_ready,
   output item_type  rd_item,
   output logic      rd_valid,
   input  wire logic rd_ready
);
   item_type mem_ff [2];
   logic     wp_ff, rp_ff;
   logic [1:0] cnt_ff;
   logic wr, rd;

   assign wr_ready = (cnt_ff != 2'd2);
   assign rd_valid = (cnt_ff != 2'd0);
   assign rd_item  = mem_ff[rp_ff];
   assign wr = wr_valid && wr_ready;
   assign rd = rd_valid && rd_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (wr) wp_ff <= !wp_ff;
         if (rd) rp_ff <= !rp_ff;
         cnt_ff <= cnt_ff + {1'b0, wr} - {1'b0, rd};
      end
      if (wr) mem_ff[wp_ff] <= wr_item;
   end
endmodule
`default_nettype wire

@@ rtl/core/fasm_back.sv @@
// back end: align, add or multiply, normalize and pack
`default_nettype none
module fasm_back import fasm_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   input  item_type  item,
   input  wire logic item_valid,
   output logic      item_ready,
   fasm_rsp_if.source rsp
);
   // stage 1 computes the raw magnitude; stage 2 normalizes and packs
   logic        v1_ff;
   logic        byp_ff;
   logic [31:0] bw_ff, mag_ff, sign_ff;
   logic signed [10:0] e_ff;
   logic        v2_ff;
   logic [31:0] res_ff;
   logic        adv1, adv2;

   logic signed [10:0] de;
   logic [31:0] f1, f2, total, mag_in, sign_in;
   logic signed [10:0] e_in;
   logic [15:0] m1, m2;

   logic [31:0] nm;
   logic signed [10:0] ne;
   logic [4:0] lz;
   logic [31:0] pack_in;

   assign adv2 = !v2_ff || rsp.ready;
   assign adv1 = !v1_ff || adv2;
   assign item_ready = adv1;
   assign rsp.valid = v2_ff;
   assign rsp.result_word = res_ff;

   function automatic logic [31:0] asr(input logic [31:0] x, input logic signed [10:0] n);
      logic [31:0] r;
      if (n <= 0) r = x;
      else if (n >= 32) r = {32{x[31]}};
      else r = 32'($signed(x) >>> n[4:0]);
      asr = r;
   endfunction

   always_comb begin
      f1 = item.s1 ? (32'd0 - item.f1) : item.f1;
      f2 = item.s2 ? (32'd0 - item.f2) : item.f2;
      de = 11'(item.e1) - 11'(item.e2);
      e_in = (item.e1 >= item.e2) ? 11'(item.e1) : 11'(item.e2);
      if (de > 0) f2 = asr(f2, de);
      else if (de < 0) f1 = asr(f1, -de);
      if (item.s1 == item.s2) begin
         f1 = asr(f1, 11'sd1);
         f2 = asr(f2, 11'sd1);
         e_in = e_in + 11'sd1;
      end
      total = f1 + f2;
      sign_in = (item.s1 == item.s2) ? {item.s1, 31'd0} : (total & SIGN_BIT);
      mag_in = sign_in[31] ? (32'd0 - total) : total;
      m1 = item.f1[31:16];
      m2 = item.f2[31:16];
      if (item.is_mul) begin
         mag_in = {16'd0, m1} * {16'd0, m2};
         sign_in = {item.s1 ^ item.s2, 31'd0};
         e_in = 11'(item.e1) + 11'(item.e2) + 11'sd2;
      end
   end

   always_comb begin
      lz = 5'd0;
      for (int i = 30; i >= 0; i--) begin
         if (mag_ff[i] && lz == 5'd0 && !(|(mag_ff[30:0] >> (i + 1)))) lz = 5'(30 - i);
      end
      if (mag_ff[31]) begin
         nm = mag_ff >> 1;
         ne = e_ff + 11'sd1;
      end else begin
         nm = mag_ff << lz;
         ne = e_ff - 11'(lz);
      end
      pack_in = sign_ff + ((nm >> 7) & MANT_MASK)
              + (32'($signed(ne) + 32'sd127) << MANT_BITS);
      if (mag_ff == 32'd0) pack_in = 32'd0;
      if (byp_ff) pack_in = bw_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         if (adv1) v1_ff <= item_valid;
         if (adv2) v2_ff <= v1_ff;
      end
      if (adv1 && item_valid) begin
         byp_ff <= item.bypass;
         bw_ff <= item.bypass_word;
         mag_ff <= mag_in;
         sign_ff <= sign_in;
         e_ff <= e_in;
      end
      if (adv2 && v1_ff) res_ff <= pack_in;
   end
endmodule
`default_nettype wire

@@ tb/tb.sv @@
// self-checking testbench for the float32 add/sub/mul unit
`default_nettype none
module tb;
   import fasm_pkg::*;

   typedef struct packed {
      logic [1:0]  op;
      logic [31:0] a;
      logic [31:0] b;
   } op_item;

   localparam int IDLE_LIMIT = 5000;
   localparam int HOLD_CYCLES = 300;

   logic clock;
   logic reset;
   fasm_req_if req ();
   fasm_rsp_if rsp ();

   float32_add_sub_mul_top uut (.clock(clock), .reset(reset), .req(req), .rsp(rsp));

   op_item      pending_ops[$];
   logic [31:0] expected_words[$];
   int          error_count = 0;
   int          req_wait = 0;
   int          rsp_wait = 0;
   int          hold_left = 0;
   int          hold_done = 0;
   int          rsp_count = 0;
   int          idle_cycles = 0;
   bit          stim_done = 0;

   function automatic logic [31:0] shift_right_arith(logic [31:0] x, int n);
      if (n <= 0) return x;
      if (n >= 32) return x[31] ? 32'hffff_ffff : 32'h0;
      return $unsigned($signed(x) >>> n);
   endfunction

   function automatic logic [31:0] unpack_frac(logic [31:0] w);
      return {2'b01, w[22:0], 7'b0};
   endfunction

   function automatic int exp_of(logic [31:0] w);
      return int'(w[30:23]) - EXP_BIAS;
   endfunction

   function automatic logic [31:0] pack_word(logic [31:0] sign, int e, logic [31:0] mag);
      if (mag == 0) return 32'h0;
      if (mag[31]) begin
         mag = mag >> 1;
         e++;
      end else begin
         while (mag[30] == 1'b0) begin
            mag = mag << 1;
            e--;
         end
      end
      return sign + ((mag >> 7) & MANT_MASK) + (32'(e + EXP_BIAS) << MANT_BITS);
   endfunction

   function automatic logic [31:0] float_sum(logic [31:0] a, logic [31:0] b);
      logic [31:0] s1, s2, f1, f2, total, sign;
      int e1, e2;
      if (a[30:0] == 0) return b;
      if (b[30:0] == 0) return a;
      s1 = a & SIGN_BIT;
      s2 = b & SIGN_BIT;
      e1 = exp_of(a);
      e2 = exp_of(b);
      f1 = unpack_frac(a);
      f2 = unpack_frac(b);
      if (s1 != 0) f1 = -f1;
      if (s2 != 0) f2 = -f2;
      if (e1 > e2) f2 = shift_right_arith(f2, e1 - e2);
      else if (e2 > e1) f1 = shift_right_arith(f1, e2 - e1);
      if (s1 == s2) begin
         f1 = shift_right_arith(f1, 1);
         f2 = shift_right_arith(f2, 1);
         e1++;
         e2++;
      end
      total = f1 + f2;
      sign = (s1 == s2) ? s1 : (total & SIGN_BIT);
      return pack_word(sign, (e1 >= e2) ? e1 : e2, (sign != 0) ? -total : total);
   endfunction

   function automatic logic [31:0] float_product(logic [31:0] a, logic [31:0] b);
      if (a[30:0] == 0 || b[30:0] == 0) return 32'h0;
      return pack_word((a ^ b) & SIGN_BIT, exp_of(a) + exp_of(b) + 2,
                       (unpack_frac(a) >> 16) * (unpack_frac(b) >> 16));
   endfunction

   function automatic logic [31:0] predict_word(op_item it);
      if (it.op[1]) return float_product(it.a, it.b);
      if (it.op == OP_SUB) return float_sum(it.a, it.b ^ SIGN_BIT);
      return float_sum(it.a, it.b);
   endfunction

   function automatic logic [31:0] random_operand();
      logic [31:0] w;
      w = $urandom;
      case ($urandom_range(0, 5))
         0: w[30:0] = 31'h0;
         1: w[30:23] = 8'(127 + $urandom_range(0, 8) - 4);
         2: w[30:23] = 8'($urandom_range(0, 1) ? 8'hff : 8'h00);
         default: ;
      endcase
      return w;
   endfunction

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      op_item it;
      logic [31:0] edge_vals[8];
      edge_vals = '{32'h0, 32'h8000_0000, 32'h3f80_0000, 32'hbf80_0000,
                    32'h7fff_ffff, 32'hffff_ffff, 32'h0080_0000, 32'h4b7f_ffff};
      for (int i = 0; i < 24; i++) begin
         it.op = 2'(i % 4);
         it.a = edge_vals[i % 8];
         it.b = edge_vals[(i / 3 + 5) % 8];
         pending_ops.push_back(it);
      end
      it = '{OP_ADD, 32'h3f80_0000, 32'hbf80_0000};
      pending_ops.push_back(it);
      for (int i = 0; i < 1900; i++) begin
         it.op = ($urandom_range(0, 15) == 0) ? OP_MUL_ALT : 2'($urandom_range(0, 2));
         it.a = random_operand();
         it.b = ($urandom_range(0, 7) == 0) ? it.a : random_operand();
         if ($urandom_range(0, 9) == 0) it.b = it.a ^ SIGN_BIT;
         pending_ops.push_back(it);
      end
   end

   initial begin
      reset = 1;
      repeat (2) @(posedge clock);
      reset <= 0;
   end

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req.valid <= 0;
         req.req_type <= OP_ADD;
         req.operand_a <= 0;
         req.operand_b <= 0;
         req_wait <= $urandom_range(0, 19);
      end else begin
         if (req.valid && req.ready) begin
            expected_words.push_back(predict_word('{req.req_type, req.operand_a,
                                                    req.operand_b}));
         end
         if (!req.valid || req.ready) begin
            if (req_wait > 0 || pending_ops.size() == 0) begin
               req.valid <= 0;
               if (req_wait > 0) req_wait <= req_wait - 1;
               if (pending_ops.size() == 0 && !(req.valid && !req.ready)) stim_done <= 1;
            end else begin
               op_item it;
               it = pending_ops.pop_front();
               req.valid <= 1;
               req.req_type <= it.op;
               req.operand_a <= it.a;
               req.operand_b <= it.b;
               req_wait <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 19) : 0;
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 0;
         rsp_wait <= 0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            logic [31:0] want;
            rsp_count <= rsp_count + 1;
            if (expected_words.size() == 0) begin
               $display("%0t: unexpected transfer, actual %h", $realtime, rsp.result_word);
               error_count <= error_count + 1;
            end else begin
               want = expected_words.pop_front();
               if (rsp.result_word !== want) begin
                  $display("%0t: result_word mismatch, expected %h actual %h",
                           $realtime, want, rsp.result_word);
                  error_count <= error_count + 1;
               end
            end
         end
         if (hold_done == 0 && rsp_count == 100) begin
            hold_done <= 1;
            hold_left <= HOLD_CYCLES;
            rsp.ready <= 0;
         end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp.ready <= 0;
         end else if (rsp_wait > 0) begin
            rsp_wait <= rsp_wait - 1;
            rsp.ready <= 0;
         end else begin
            rsp.ready <= 1;
            if (rsp.valid && rsp.ready && $urandom_range(0, 3) == 0)
               rsp_wait <= $urandom_range(0, 19);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      wait (stim_done);
      wait (expected_words.size() == 0);
      repeat (20) @(posedge clock);
      if (error_count == 0 && expected_words.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end
endmodule
`default_nettype wire

@@ float32_add_sub_mul_top.f @@
rtl/core/fasm_pkg.sv
rtl/core/fasm_if.sv
rtl/core/fasm_front.sv
rtl/core/fasm_queue.sv
rtl/core/fasm_back.sv
rtl/core/float32_add_sub_mul_top.sv
tb/tb.sv
